// ===== design/efsd_pkg.sv =====
package efsd_pkg;

    // Window count of the free-time store.
    localparam int MAX_WINDOWS = 16;
    localparam int IDX_W       = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;
    localparam int CNT_W       = $clog2(MAX_WINDOWS + 1);

    localparam int SEC_W   = 17;
    localparam int MIN_W   = 8;
    localparam int SVC_W   = 14;
    localparam int FREE_W  = 32;
    localparam int WAIT_W  = 24;
    localparam int TOTAL_W = 40;
    localparam int COUNT_W = 24;
    localparam int ACT_W   = 5;
    localparam int CFG_W   = 17;

    localparam logic [ACT_W-1:0]   ACTIVE_RESET = 5'd16;
    localparam logic [SEC_W-1:0]   OPEN_RESET   = 17'd28800;
    localparam logic [SEC_W-1:0]   CLOSE_RESET  = 17'd61200;
    localparam logic [SVC_W-1:0]   SEC_PER_MIN  = 14'd60;
    localparam logic [FREE_W-1:0]  FREE_MAX     = '1;
    localparam logic [WAIT_W-1:0]  WAIT_MAX     = '1;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX    = '1;
    localparam logic [COUNT_W-1:0] COUNT_MAX    = '1;

    typedef enum logic [1:0] {
        CFG_ACTIVE_WINDOWS = 2'd0,
        CFG_OPEN_TIME      = 2'd1,
        CFG_CLOSE_TIME     = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_UPDATE,
        S_TOTAL,
        S_REPORT
    } t_state;

    typedef struct packed {
        logic [SEC_W-1:0] arrival_sec;
        logic [MIN_W-1:0] service_min;
    } t_in;

    typedef struct packed {
        logic               accepted;
        logic [3:0]         window_index;
        logic [WAIT_W-1:0]  wait_sec;
        logic [TOTAL_W-1:0] total_wait_sec;
        logic [COUNT_W-1:0] served_count;
    } t_out;

    typedef struct packed {
        logic [ACT_W-1:0] active_windows;
        logic [SEC_W-1:0] open_time_sec;
        logic [SEC_W-1:0] close_time_sec;
        logic             reload;
    } t_cfg;

endpackage

// ===== design/efsd_ram.sv =====
module efsd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic                                       i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/efsd_engine.sv =====
module efsd_engine
    import efsd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cfg i_cfg,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in,
    output logic o_res_valid,
    input  logic i_out_free,
    output t_out o_res
);

    t_state r_state;
    t_state n_state;

    logic [SEC_W-1:0]       r_arrival;
    logic [SVC_W-1:0]       r_service;
    logic                   r_ok;
    logic [CNT_W-1:0]       r_issue;
    logic                   r_cmp_valid;
    logic [IDX_W-1:0]       r_cmp_idx;
    logic [FREE_W-1:0]      r_best_free;
    logic [IDX_W-1:0]       r_best_idx;
    logic [WAIT_W-1:0]      r_wait;
    logic [TOTAL_W-1:0]     r_total;
    logic [COUNT_W-1:0]     r_count;
    logic [MAX_WINDOWS-1:0] r_valid;

    logic               w_rd_en;
    logic [IDX_W-1:0]   w_rd_addr;
    logic               w_wr_en;
    logic [FREE_W-1:0]  w_wr_data;
    logic [FREE_W-1:0]  w_rdata;
    logic [CNT_W-1:0]   w_limit;
    logic [IDX_W-1:0]   w_last;
    logic [FREE_W-1:0]  w_cand;
    logic               w_accept;
    logic               w_ok;
    logic               w_busy;
    logic [FREE_W-1:0]  w_arr_ext;
    logic [FREE_W-1:0]  w_wait_full;
    logic [FREE_W:0]    w_next_sum;
    logic [WAIT_W-1:0]  w_wait_sat;
    logic [TOTAL_W:0]   w_total_sum;

    // Window count clamped to the range of the store.
    always_comb begin
        if (i_cfg.active_windows == '0) begin
            w_limit = CNT_W'(1);
        end else if (int'(i_cfg.active_windows) > MAX_WINDOWS) begin
            w_limit = CNT_W'(MAX_WINDOWS);
        end else begin
            w_limit = CNT_W'(i_cfg.active_windows);
        end
    end

    assign w_last    = IDX_W'(w_limit - CNT_W'(1));
    assign w_accept  = i_in_valid && o_in_ready;
    assign w_ok      = i_in.arrival_sec <= i_cfg.close_time_sec;

    // An entry not written since reset or the last reload holds the opening time.
    assign w_cand = r_valid[r_cmp_idx] ? w_rdata : FREE_W'(i_cfg.open_time_sec);

    assign w_arr_ext   = FREE_W'(r_arrival);
    assign w_busy      = r_best_free > w_arr_ext;
    assign w_wait_full = r_best_free - w_arr_ext;
    assign w_next_sum  = w_busy ? ({1'b0, r_best_free} + (FREE_W + 1)'(r_service))
                                : ((FREE_W + 1)'(w_arr_ext) + (FREE_W + 1)'(r_service));
    assign w_wr_data   = w_next_sum[FREE_W] ? FREE_MAX : w_next_sum[FREE_W-1:0];
    assign w_wait_sat  = !w_busy ? '0
                       : ((w_wait_full > FREE_W'(WAIT_MAX)) ? WAIT_MAX
                                                            : w_wait_full[WAIT_W-1:0]);
    assign w_total_sum = {1'b0, r_total} + (TOTAL_W + 1)'(r_wait);

    efsd_ram #(
        .WIDTH(FREE_W),
        .DEPTH(MAX_WINDOWS)
    ) u_free_ram (
        .i_clk  (i_clk),
        .i_we   (w_wr_en),
        .i_waddr(r_best_idx),
        .i_wdata(w_wr_data),
        .i_re   (w_rd_en),
        .i_raddr(w_rd_addr),
        .o_rdata(w_rdata)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = w_ok ? S_SCAN : S_REPORT;
                end
            end
            S_SCAN: begin
                if (r_cmp_valid && (r_cmp_idx == w_last)) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: n_state = S_TOTAL;
            S_TOTAL:  n_state = S_REPORT;
            S_REPORT: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready  = 1'b0;
        o_res_valid = 1'b0;
        w_rd_en     = 1'b0;
        w_wr_en     = 1'b0;
        w_rd_addr   = r_issue[IDX_W-1:0];
        case (r_state)
            S_IDLE:   o_in_ready  = 1'b1;
            S_SCAN:   w_rd_en     = r_issue < w_limit;
            S_UPDATE: w_wr_en     = 1'b1;
            S_TOTAL:  w_wr_en     = 1'b0;
            S_REPORT: o_res_valid = 1'b1;
            default:  o_in_ready  = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cmp_valid <= 1'b0;
            r_issue     <= '0;
            r_valid     <= '0;
            r_total     <= '0;
            r_count     <= '0;
            r_ok        <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cmp_valid <= w_rd_en;
            if (w_accept) begin
                r_ok    <= w_ok;
                r_issue <= '0;
            end else if (w_rd_en) begin
                r_issue <= r_issue + CNT_W'(1);
            end
            if (i_cfg.reload) begin
                r_valid <= '0;
            end else if (w_wr_en) begin
                r_valid[r_best_idx] <= 1'b1;
            end
            if (r_state == S_TOTAL) begin
                r_total <= w_total_sum[TOTAL_W] ? TOTAL_MAX : w_total_sum[TOTAL_W-1:0];
                if (r_count != COUNT_MAX) begin
                    r_count <= r_count + COUNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_arrival <= i_in.arrival_sec;
            r_service <= SVC_W'(i_in.service_min) * SEC_PER_MIN;
        end
        if (w_rd_en) begin
            r_cmp_idx <= w_rd_addr;
        end
        // Strict compare keeps the lowest index on ties.
        if (r_cmp_valid && ((r_cmp_idx == '0) || (w_cand < r_best_free))) begin
            r_best_free <= w_cand;
            r_best_idx  <= r_cmp_idx;
        end
        if (r_state == S_UPDATE) begin
            r_wait <= w_wait_sat;
        end
    end

    always_comb begin
        o_res.accepted       = r_ok;
        o_res.window_index   = r_ok ? 4'(r_best_idx) : 4'd0;
        o_res.wait_sec       = r_ok ? r_wait : '0;
        o_res.total_wait_sec = r_total;
        o_res.served_count   = r_count;
    end

endmodule

// ===== design/earliest_free_server_dispatch.sv =====
// Earliest-free-server dispatcher: each input transaction is one customer
// (arrival second of day, service minutes) and yields exactly one output
// transaction. A customer arriving after the closing second is rejected and
// reported with zero window and wait. Otherwise the customer goes to the
// active window with the earliest free time (lowest index on ties), and the
// block reports the wait, the saturating running total of waits and the
// saturating count of customers served. The window free times live in a
// single-port-read, single-port-write RAM with a registered read port;
// the controller reads them one per cycle to find the minimum, then writes
// the chosen entry back. One customer is in flight at a time: an accepted
// customer passes through the scan of the active windows (clamped to 1..16),
// the write-back of the chosen entry and the update of the total and count
// before it reaches the output register, and no new customer is taken until
// the output register has taken its result. A rejected customer skips those
// steps and goes straight to the output register. The time per customer is
// set by the sequential scan of the free-time RAM through its one read port.
// Writing the opening time reloads every window's free time at once;
// configuration should be written only while no customer is in flight.
module earliest_free_server_dispatch
    import efsd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in              i_in,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out             o_out,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data
);

    logic [ACT_W-1:0] r_active_windows;
    logic [SEC_W-1:0] r_open_time;
    logic [SEC_W-1:0] r_close_time;
    logic             r_out_valid;
    t_out             r_out;
    t_cfg             w_cfg;
    t_out             w_res;
    logic             w_res_valid;
    logic             w_out_free;

    // Configuration registers. A write to the opening time also tells the
    // engine to treat every window as free from the new opening second.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_windows <= ACTIVE_RESET;
            r_open_time      <= OPEN_RESET;
            r_close_time     <= CLOSE_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_ACTIVE_WINDOWS: r_active_windows <= i_cfg_data[ACT_W-1:0];
                CFG_OPEN_TIME:      r_open_time      <= i_cfg_data[SEC_W-1:0];
                CFG_CLOSE_TIME:     r_close_time     <= i_cfg_data[SEC_W-1:0];
                default:            r_close_time     <= r_close_time;
            endcase
        end
    end

    always_comb begin
        w_cfg.active_windows = r_active_windows;
        w_cfg.open_time_sec  = r_open_time;
        w_cfg.close_time_sec = r_close_time;
        w_cfg.reload         = i_cfg_we && (t_cfg_idx'(i_cfg_index) == CFG_OPEN_TIME);
    end

    // The output register is free when empty or when its transaction is
    // being taken in this cycle.
    assign w_out_free = !r_out_valid || i_out_ready;

    efsd_engine u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (w_cfg),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (i_in),
        .o_res_valid(w_res_valid),
        .i_out_free (w_out_free),
        .o_res      (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free && w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule
